>>> hdl/dsf_pkg.sv
// Shared types, codes and defaults for the dominated strategy filter.
// No dependencies; every other file imports this package.
package dsf_pkg;

    localparam int MAX_STRATEGIES_DEFAULT    = 16;
    localparam int MAX_CONTINGENCIES_DEFAULT = 256;
    localparam int PAYOFF_WIDTH_DEFAULT      = 32;

    localparam int RESULT_LIMIT = 16;

    localparam int STRATEGY_IDX_W    = 4;
    localparam int CONTINGENCY_IDX_W = 8;
    localparam int PAYOFF_IN_W       = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int STRAT_CNT_W = 5;
    localparam int CONT_CNT_W  = 9;

    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STRICT_MODE,
        CFG_STRATEGY_COUNT,
        CFG_CONTINGENCY_COUNT
    } dsf_cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DRAIN,
        ST_EMIT
    } dsf_state_t;

endpackage

>>> hdl/dsf_channels.sv
// Valid/ready channel interfaces for input items and result beats.
// Depends on dsf_pkg for the field widths.
interface dsf_item_if
    import dsf_pkg::*;
    ();
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic        [STRATEGY_IDX_W-1:0]    strategy_index;
    logic        [CONTINGENCY_IDX_W-1:0] contingency_index;
    logic signed [PAYOFF_IN_W-1:0]       payoff_value;

    modport source (output valid, operation, strategy_index, contingency_index,
                    payoff_value, input ready);
    modport sink   (input valid, operation, strategy_index, contingency_index,
                    payoff_value, output ready);
endinterface

interface dsf_result_if
    import dsf_pkg::*;
    ();
    logic                      valid;
    logic                      ready;
    logic [STRATEGY_IDX_W-1:0] result_strategy;
    logic                      kept;
    logic                      last_result;

    modport source (output valid, result_strategy, kept, last_result, input ready);
    modport sink   (input valid, result_strategy, kept, last_result, output ready);
endinterface

>>> hdl/dominated_strategy_filter.sv
// Dominated strategy filter: payoff matrix in a two-read-port memory, pairwise walk.
// Depends on dsf_pkg and on the channel interfaces in dsf_channels.sv.
// A load beat writes one payoff. An evaluate beat walks rows * rows * cols payoff
// pairs, one pair read from the memory per cycle, then drains the last read,
// followed by one result beat per strategy, one per cycle when the sink is ready.
// Reset initialises the config, kept flags and control; the memory is not cleared.
module dominated_strategy_filter
    import dsf_pkg::*;
#(
    parameter int MAX_STRATEGIES    = MAX_STRATEGIES_DEFAULT,
    parameter int MAX_CONTINGENCIES = MAX_CONTINGENCIES_DEFAULT,
    parameter int PAYOFF_WIDTH      = PAYOFF_WIDTH_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    dsf_item_if.sink               items,
    dsf_result_if.source           results
);

    localparam int RW        = $clog2(MAX_STRATEGIES);
    localparam int CW        = (MAX_CONTINGENCIES > 1) ? $clog2(MAX_CONTINGENCIES) : 1;
    localparam int DEPTH     = 2 ** (RW + CW);
    localparam int ROW_LIMIT = (MAX_STRATEGIES < RESULT_LIMIT) ? MAX_STRATEGIES
                                                               : RESULT_LIMIT;

    logic                   strict_mode_reg;
    logic [STRAT_CNT_W-1:0] strategy_count_reg;
    logic [CONT_CNT_W-1:0]  contingency_count_reg;

    dsf_state_t state_reg;
    dsf_state_t state_next;

    logic [STRATEGY_IDX_W-1:0] row_last;
    logic [CW-1:0]             col_last;

    logic [STRATEGY_IDX_W-1:0] i_reg;
    logic [STRATEGY_IDX_W-1:0] j_reg;
    logic [CW-1:0]             c_reg;
    logic [STRATEGY_IDX_W-1:0] out_idx_reg;

    logic                      rd_valid_reg;
    logic                      rd_first_reg;
    logic                      rd_last_reg;
    logic                      rd_pair_reg;
    logic [STRATEGY_IDX_W-1:0] rd_row_reg;

    logic ge_all_reg;
    logic gt_any_reg;
    logic gt_all_reg;
    logic [RESULT_LIMIT-1:0] kept_reg;

    logic signed [PAYOFF_WIDTH-1:0] payoff_mem [DEPTH];
    logic signed [PAYOFF_WIDTH-1:0] rd_a_reg;
    logic signed [PAYOFF_WIDTH-1:0] rd_b_reg;

    logic                    in_fire;
    logic                    out_fire;
    logic                    load_ok;
    logic                    mem_we;
    logic [RW+CW-1:0]        wr_addr;
    logic [PAYOFF_WIDTH-1:0] wr_data;
    logic [RW+CW-1:0]        rd_addr_a;
    logic [RW+CW-1:0]        rd_addr_b;
    logic                    issue_last;
    logic                    a_ge;
    logic                    a_gt;
    logic                    ge_all_cur;
    logic                    gt_any_cur;
    logic                    gt_all_cur;
    logic                    beats;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strict_mode_reg       <= 1'b0;
            strategy_count_reg    <= STRAT_CNT_W'(1);
            contingency_count_reg <= CONT_CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_STRICT_MODE:       strict_mode_reg       <= cfg_data[0];
                CFG_STRATEGY_COUNT:    strategy_count_reg    <= cfg_data[STRAT_CNT_W-1:0];
                CFG_CONTINGENCY_COUNT: contingency_count_reg <= cfg_data[CONT_CNT_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        if (strategy_count_reg == '0)
            row_last = '0;
        else if (strategy_count_reg >= ROW_LIMIT)
            row_last = STRATEGY_IDX_W'(ROW_LIMIT - 1);
        else
            row_last = STRATEGY_IDX_W'(strategy_count_reg - STRAT_CNT_W'(1));

        if (contingency_count_reg == '0)
            col_last = '0;
        else if (contingency_count_reg >= MAX_CONTINGENCIES)
            col_last = CW'(MAX_CONTINGENCIES - 1);
        else
            col_last = CW'(contingency_count_reg - CONT_CNT_W'(1));
    end

    assign items.ready = (state_reg == ST_IDLE);
    assign in_fire     = items.valid && items.ready;
    assign out_fire    = results.valid && results.ready;

    assign load_ok = (32'(items.strategy_index) < MAX_STRATEGIES)
                  && (32'(items.contingency_index) < MAX_CONTINGENCIES);
    assign mem_we  = in_fire && (items.operation == OP_LOAD) && load_ok;
    assign wr_addr = {RW'(items.strategy_index), CW'(items.contingency_index)};
    assign wr_data = PAYOFF_WIDTH'($unsigned(items.payoff_value));

    assign rd_addr_a = {RW'(j_reg), c_reg};
    assign rd_addr_b = {RW'(i_reg), c_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            payoff_mem[wr_addr] <= wr_data;
        rd_a_reg <= payoff_mem[rd_addr_a];
        rd_b_reg <= payoff_mem[rd_addr_b];
    end

    assign issue_last = (c_reg == col_last) && (j_reg == row_last) && (i_reg == row_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (items.operation == OP_EVALUATE))
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (issue_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_fire && (out_idx_reg == row_last))
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign a_ge       = (rd_a_reg >= rd_b_reg);
    assign a_gt       = (rd_a_reg > rd_b_reg);
    assign ge_all_cur = (rd_first_reg || ge_all_reg) && a_ge;
    assign gt_any_cur = (!rd_first_reg && gt_any_reg) || a_gt;
    assign gt_all_cur = (rd_first_reg || gt_all_reg) && a_gt;
    assign beats      = strict_mode_reg ? gt_all_cur : (ge_all_cur && gt_any_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg        <= '0;
            j_reg        <= '0;
            c_reg        <= '0;
            out_idx_reg  <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            rd_pair_reg  <= 1'b0;
            rd_row_reg   <= '0;
            ge_all_reg   <= 1'b0;
            gt_any_reg   <= 1'b0;
            gt_all_reg   <= 1'b0;
            kept_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= (state_reg == ST_EVAL);

            if (in_fire && (items.operation == OP_EVALUATE))
            begin
                i_reg       <= '0;
                j_reg       <= '0;
                c_reg       <= '0;
                out_idx_reg <= '0;
                kept_reg    <= '1;
            end

            if (state_reg == ST_EVAL)
            begin
                rd_first_reg <= (c_reg == '0);
                rd_last_reg  <= (c_reg == col_last);
                rd_pair_reg  <= (i_reg != j_reg);
                rd_row_reg   <= i_reg;
                if (c_reg == col_last)
                begin
                    c_reg <= '0;
                    if (j_reg == row_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + STRATEGY_IDX_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + STRATEGY_IDX_W'(1);
                    end
                end
                else
                begin
                    c_reg <= c_reg + CW'(1);
                end
            end

            if (rd_valid_reg)
            begin
                ge_all_reg <= ge_all_cur;
                gt_any_reg <= gt_any_cur;
                gt_all_reg <= gt_all_cur;
                if (rd_last_reg && rd_pair_reg && beats)
                    kept_reg[rd_row_reg] <= 1'b0;
            end

            if (out_fire)
                out_idx_reg <= out_idx_reg + STRATEGY_IDX_W'(1);
        end
    end

    assign results.valid           = (state_reg == ST_EMIT);
    assign results.result_strategy = out_idx_reg;
    assign results.kept            = kept_reg[out_idx_reg];
    assign results.last_result     = (out_idx_reg == row_last);

    // No new item is taken while result beats are still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !results.valid)
        else $error("input beat accepted while results are pending");

    // The final result beat ends the evaluate.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && results.last_result |=> !results.valid)
        else $error("result beats continue after the final one");

    // Compare data only arrives during the pair walk or its drain state.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_EVAL) || (state_reg == ST_DRAIN))
        else $error("memory read data outside the pair walk");

    // The payoff memory is never written while it is being walked.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == ST_IDLE) && !rd_valid_reg)
        else $error("payoff write during evaluation");

endmodule

>>> tb/tb.sv
// Self-checking testbench for dominated_strategy_filter: loads payoff matrices, evaluates
// dominance in strict and weak mode and checks every result beat against its prediction.
// Depends on dsf_pkg, the channel interfaces in dsf_channels.sv and the filter RTL.
module tb;
    import dsf_pkg::*;

    localparam int RANDOM_ITEMS    = 260;
    localparam int FULL_FILL_LIMIT = 64;
    localparam int QUIET_CYCLES    = 4;
    localparam int TAIL_CYCLES     = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 20000;

    localparam logic [CFG_INDEX_W-1:0]        CFG_SPARE_INDEX = 2'd3;
    localparam logic signed [PAYOFF_IN_W-1:0] PAYOFF_MIN      = 32'sh8000_0000;
    localparam logic signed [PAYOFF_IN_W-1:0] PAYOFF_MAX      = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic                                operation;
        logic        [STRATEGY_IDX_W-1:0]    strategy_index;
        logic        [CONTINGENCY_IDX_W-1:0] contingency_index;
        logic signed [PAYOFF_IN_W-1:0]       payoff_value;
    } payoff_item_t;

    typedef struct packed {
        logic [STRATEGY_IDX_W-1:0] strategy;
        logic                      kept;
        logic                      last_result;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dsf_item_if   item_bus ();
    dsf_result_if result_bus ();

    dominated_strategy_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (item_bus),
        .results   (result_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted contents of the block: payoff matrix and register copies.
    logic signed [PAYOFF_IN_W-1:0] payoff_model
        [MAX_STRATEGIES_DEFAULT][MAX_CONTINGENCIES_DEFAULT];
    logic                          model_strict            = 1'b0;
    logic [STRAT_CNT_W-1:0]        model_strategy_count    = 1;
    logic [CONT_CNT_W-1:0]         model_contingency_count = 1;

    // What the stimulus side has already written, so that no evaluation reads a stale entry.
    logic signed [PAYOFF_IN_W-1:0] payoff_plan
        [MAX_STRATEGIES_DEFAULT][MAX_CONTINGENCIES_DEFAULT];
    bit                            payoff_written
        [MAX_STRATEGIES_DEFAULT][MAX_CONTINGENCIES_DEFAULT];

    payoff_item_t items_pending[$];
    verdict_t     verdicts_expected[$];

    int unsigned items_queued       = 0;
    int unsigned loads_accepted     = 0;
    int unsigned evaluations_seen   = 0;
    int unsigned verdicts_checked   = 0;
    int unsigned register_writes    = 0;
    int unsigned mismatch_count     = 0;
    int unsigned stalled_cycles     = 0;

    int unsigned tx_gap;
    bit          tx_no_idle;
    int unsigned rx_stall;
    bit          rx_no_idle;
    bit          pressure_armed = 1'b0;
    bit          pressure_done;

    function automatic int effective_rows();
        int n;
        n = model_strategy_count;
        if (n < 1) n = 1;
        if (n > MAX_STRATEGIES_DEFAULT) n = MAX_STRATEGIES_DEFAULT;
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        return n;
    endfunction

    function automatic int effective_cols();
        int n;
        n = model_contingency_count;
        if (n < 1) n = 1;
        if (n > MAX_CONTINGENCIES_DEFAULT) n = MAX_CONTINGENCIES_DEFAULT;
        return n;
    endfunction

    function automatic void apply_payoff_item(input payoff_item_t item);
        int                            rows;
        int                            cols;
        bit                            keep;
        bit                            beats;
        bit                            greater;
        logic signed [PAYOFF_IN_W-1:0] pa;
        logic signed [PAYOFF_IN_W-1:0] pb;
        verdict_t                      verdict;
        if (item.operation == OP_LOAD)
        begin
            payoff_model[item.strategy_index][item.contingency_index] = item.payoff_value;
            loads_accepted++;
            return;
        end
        rows = effective_rows();
        cols = effective_cols();
        for (int i = 0; i < rows; i++)
        begin
            keep = 1'b1;
            for (int j = 0; j < rows; j++)
            begin
                if (j != i && keep)
                begin
                    beats   = 1'b1;
                    greater = 1'b0;
                    for (int c = 0; c < cols; c++)
                    begin
                        pa = payoff_model[j][c];
                        pb = payoff_model[i][c];
                        if (model_strict ? (pa <= pb) : (pa < pb)) beats = 1'b0;
                        if (pa > pb) greater = 1'b1;
                    end
                    if (beats && (model_strict || greater)) keep = 1'b0;
                end
            end
            verdict.strategy    = STRATEGY_IDX_W'(i);
            verdict.kept        = keep;
            verdict.last_result = (i == rows - 1);
            verdicts_expected.push_back(verdict);
        end
        evaluations_seen++;
    endfunction

    function automatic logic signed [PAYOFF_IN_W-1:0] draw_payoff();
        int unsigned pick;
        int          whole;
        pick  = $urandom_range(0, 9);
        whole = int'($urandom_range(0, 6)) - 3;
        if (pick == 0) return PAYOFF_MIN;
        if (pick == 1) return PAYOFF_MAX;
        if (pick == 2) return $urandom;
        return whole * 65536;
    endfunction

    function automatic void queue_payoff_load(input int s, input int c,
                                              input logic signed [PAYOFF_IN_W-1:0] v);
        payoff_item_t item;
        item.operation         = OP_LOAD;
        item.strategy_index    = STRATEGY_IDX_W'(s);
        item.contingency_index = CONTINGENCY_IDX_W'(c);
        item.payoff_value      = v;
        payoff_plan[s][c]      = v;
        payoff_written[s][c]   = 1'b1;
        items_pending.push_back(item);
        items_queued++;
    endfunction

    function automatic void queue_evaluation();
        payoff_item_t item;
        item.operation         = OP_EVALUATE;
        item.strategy_index    = STRATEGY_IDX_W'($urandom);
        item.contingency_index = CONTINGENCY_IDX_W'($urandom);
        item.payoff_value      = $urandom;
        items_pending.push_back(item);
        items_queued++;
    endfunction

    task automatic wait_quiet();
        do
            @(negedge clk);
        while (items_pending.size() != 0 || item_bus.valid || verdicts_expected.size() != 0);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            CFG_STRICT_MODE:       model_strict = value[0];
            CFG_STRATEGY_COUNT:    model_strategy_count = value[STRAT_CNT_W-1:0];
            CFG_CONTINGENCY_COUNT: model_contingency_count = value[CONT_CNT_W-1:0];
            default: ;
        endcase
        register_writes++;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : item_driver
        payoff_item_t next_item;
        if (!rst_n)
        begin
            item_bus.valid             <= 1'b0;
            item_bus.operation         <= OP_LOAD;
            item_bus.strategy_index    <= '0;
            item_bus.contingency_index <= '0;
            item_bus.payoff_value      <= '0;
            tx_gap                     <= 0;
            tx_no_idle                 <= 1'b0;
        end
        else
        begin
            if (item_bus.valid && item_bus.ready)
                apply_payoff_item({item_bus.operation, item_bus.strategy_index,
                                   item_bus.contingency_index, item_bus.payoff_value});
            if (!item_bus.valid || item_bus.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap         <= tx_gap - 1;
                    item_bus.valid <= 1'b0;
                end
                else if (items_pending.size() != 0)
                begin
                    next_item                   = items_pending.pop_front();
                    item_bus.valid             <= 1'b1;
                    item_bus.operation         <= next_item.operation;
                    item_bus.strategy_index    <= next_item.strategy_index;
                    item_bus.contingency_index <= next_item.contingency_index;
                    item_bus.payoff_value      <= next_item.payoff_value;
                    if ($urandom_range(0, 15) == 0) tx_no_idle <= !tx_no_idle;
                    tx_gap <= tx_no_idle ? 0 : $urandom_range(0, 7);
                end
                else
                begin
                    item_bus.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        int unsigned hold;
        verdict_t    want;
        if (!rst_n)
        begin
            result_bus.ready <= 1'b0;
            rx_stall         <= 0;
            rx_no_idle       <= 1'b0;
            pressure_done    <= 1'b0;
        end
        else
        begin
            hold = rx_stall;
            if (result_bus.valid && result_bus.ready)
            begin
                if (verdicts_expected.size() == 0)
                begin
                    $error("result beat with nothing expected: result_strategy %0d",
                           result_bus.result_strategy);
                    mismatch_count++;
                end
                else
                begin
                    want = verdicts_expected.pop_front();
                    verdicts_checked++;
                    if (result_bus.result_strategy !== want.strategy)
                    begin
                        $error("result_strategy: expected %0d, got %0d",
                               want.strategy, result_bus.result_strategy);
                        mismatch_count++;
                    end
                    if (result_bus.kept !== want.kept)
                    begin
                        $error("kept: expected %0b, got %0b (strategy %0d)",
                               want.kept, result_bus.kept, want.strategy);
                        mismatch_count++;
                    end
                    if (result_bus.last_result !== want.last_result)
                    begin
                        $error("last_result: expected %0b, got %0b (strategy %0d)",
                               want.last_result, result_bus.last_result, want.strategy);
                        mismatch_count++;
                    end
                end
                if ($urandom_range(0, 15) == 0) rx_no_idle <= !rx_no_idle;
                hold = rx_no_idle ? 0 : $urandom_range(0, 7);
            end
            // One long refusal of result beats while the sender keeps offering items.
            if (pressure_armed && !pressure_done && result_bus.valid)
            begin
                hold = HOLD_OFF_CYCLES;
                pressure_done <= 1'b1;
            end
            if (hold != 0)
            begin
                result_bus.ready <= 1'b0;
                rx_stall         <= hold - 1;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                rx_stall         <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready))
        begin
            stalled_cycles <= 0;
        end
        else if (stalled_cycles == WATCHDOG_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    initial
    begin
        int                            random_start;
        int                            phase;
        int                            rows;
        int                            cols;
        int                            evals;
        int unsigned                   pick;
        int unsigned                   strat;
        int unsigned                   cont;
        int unsigned                   kind;
        int                            src;
        int                            col_pick;
        int                            tie_col;
        int                            r;
        int                            c;
        bit                            by_column;
        logic signed [PAYOFF_IN_W-1:0] base;
        logic signed [PAYOFF_IN_W-1:0] v;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers at their reset values: a single strategy is always kept.
        queue_payoff_load(0, 0, PAYOFF_MIN);
        queue_evaluation();
        wait_quiet();

        write_reg(CFG_STRICT_MODE, 1);
        write_reg(CFG_STRATEGY_COUNT, 2);
        write_reg(CFG_CONTINGENCY_COUNT, 1);
        queue_payoff_load(0, 0, PAYOFF_MAX);
        queue_payoff_load(1, 0, PAYOFF_MIN);
        queue_evaluation();
        queue_payoff_load(1, 0, PAYOFF_MAX);
        queue_evaluation();
        wait_quiet();

        // Identical rows under weak dominance are both kept.
        write_reg(CFG_STRICT_MODE, 0);
        queue_evaluation();
        wait_quiet();

        // Zero counts act as one; a write past the register list changes nothing.
        write_reg(CFG_STRATEGY_COUNT, 0);
        write_reg(CFG_CONTINGENCY_COUNT, 0);
        write_reg(CFG_SPARE_INDEX, '1);
        queue_evaluation();
        wait_quiet();

        // Strategy count above the limit saturates at sixteen.
        write_reg(CFG_STRATEGY_COUNT, 31);
        write_reg(CFG_CONTINGENCY_COUNT, 1);
        for (int s = 2; s < MAX_STRATEGIES_DEFAULT; s++)
            queue_payoff_load(s, 0, draw_payoff());
        queue_evaluation();
        wait_quiet();

        // Widest matrix: row one trails row zero everywhere except a single tie.
        write_reg(CFG_STRATEGY_COUNT, 2);
        write_reg(CFG_CONTINGENCY_COUNT, 511);
        for (int k = 0; k < MAX_CONTINGENCIES_DEFAULT; k++)
        begin
            v = draw_payoff();
            if (v == PAYOFF_MIN) v = '0;
            queue_payoff_load(0, k, v);
        end
        tie_col = $urandom_range(0, MAX_CONTINGENCIES_DEFAULT - 1);
        for (int k = 0; k < MAX_CONTINGENCIES_DEFAULT; k++)
            queue_payoff_load(1, k, (k == tie_col) ? payoff_plan[0][k] : payoff_plan[0][k] - 1);
        queue_evaluation();
        wait_quiet();
        write_reg(CFG_STRICT_MODE, 1);
        queue_evaluation();
        queue_payoff_load(1, tie_col, payoff_plan[0][tie_col] - 1);
        queue_evaluation();

        random_start = items_queued;
        phase        = 0;
        while (items_queued - random_start < RANDOM_ITEMS)
        begin
            wait_quiet();
            pick = $urandom_range(0, 9);
            if (pick == 0) strat = 0;
            else if (pick == 1) strat = $urandom_range(17, 31);
            else if (pick == 2) strat = 16;
            else if (pick == 3) strat = 1;
            else strat = $urandom_range(2, 6);
            write_reg(CFG_STRATEGY_COUNT, CFG_DATA_W'(strat));
            rows = effective_rows();
            pick = $urandom_range(0, 9);
            if (rows >= 9) cont = $urandom_range(0, 3);
            else if (rows <= 2 && pick == 0)
                cont = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
            else if (pick <= 1) cont = pick;
            else if (pick <= 6) cont = $urandom_range(2, 4);
            else cont = $urandom_range(5, 16);
            write_reg(CFG_CONTINGENCY_COUNT, CFG_DATA_W'(cont));
            write_reg(CFG_STRICT_MODE, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
            cols           = effective_cols();
            pressure_armed = (phase == 1);
            evals          = (phase == 1) ? 4 : $urandom_range(1, 4);
            for (int e = 0; e < evals; e++)
            begin
                if (rows * cols <= FULL_FILL_LIMIT && (e == 0 || $urandom_range(0, 2) == 0))
                begin
                    // Random rows or earlier rows: copies, shifted by one, or one column changed.
                    for (int i = 0; i < rows; i++)
                    begin
                        kind     = $urandom_range(0, 9);
                        src      = (i == 0) ? 0 : $urandom_range(0, i - 1);
                        col_pick = $urandom_range(0, cols - 1);
                        for (int k = 0; k < cols; k++)
                        begin
                            base = payoff_plan[src][k];
                            if (i == 0 || kind >= 5) v = draw_payoff();
                            else if (kind <= 1) v = base;
                            else if (kind == 2) v = (base == PAYOFF_MAX) ? base : base + 1;
                            else if (kind == 3) v = (base == PAYOFF_MIN) ? base : base - 1;
                            else v = (k == col_pick) ? draw_payoff() : base;
                            payoff_plan[i][k] = v;
                        end
                    end
                    by_column = $urandom_range(0, 1);
                    for (int n = 0; n < rows * cols; n++)
                    begin
                        r = by_column ? n % rows : n / cols;
                        c = by_column ? n / rows : n % cols;
                        queue_payoff_load(r, c, payoff_plan[r][c]);
                    end
                end
                else
                begin
                    if (e == 0)
                        for (int i = 0; i < rows; i++)
                            for (int k = 0; k < cols; k++)
                                if (!payoff_written[i][k]) queue_payoff_load(i, k, draw_payoff());
                    repeat ($urandom_range(1, 3))
                    begin
                        r   = $urandom_range(0, rows - 1);
                        c   = $urandom_range(0, cols - 1);
                        src = $urandom_range(0, rows - 1);
                        queue_payoff_load(r, c, $urandom_range(0, 1) ? payoff_plan[src][c]
                                                                     : draw_payoff());
                    end
                end
                if ($urandom_range(0, 4) == 0)
                    queue_payoff_load($urandom_range(0, MAX_STRATEGIES_DEFAULT - 1),
                                      $urandom_range(0, MAX_CONTINGENCIES_DEFAULT - 1), $urandom);
                queue_evaluation();
            end
            phase++;
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("tb: %0d payoff loads, %0d evaluations, %0d result beats checked",
                 loads_accepted, evaluations_seen, verdicts_checked);
        $display("tb: %0d register writes; strict and weak dominance, counts from zero %s",
                 register_writes, "to saturation, one long result stall");
        if (mismatch_count == 0 && verdicts_expected.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

>>> filelist.f
hdl/dsf_pkg.sv
hdl/dsf_channels.sv
hdl/dominated_strategy_filter.sv
tb/tb.sv
